// ----- src/btba_pkg.sv -----
// ----------------------------------------------------------------------------
// btba_pkg
// Shared types and register codes of the bloom threshold, blur and add unit.
// ----------------------------------------------------------------------------
package btba_pkg;

    localparam logic [15:0] ONE_FIXED = 16'd4096;

    typedef enum logic [1:0] {
        CFG_BLOOM_ENABLE     = 2'd0,
        CFG_BRIGHT_THRESHOLD = 2'd1,
        CFG_FRAME_WIDTH      = 2'd2,
        CFG_FRAME_HEIGHT     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic        is_pad;
    } t_in_word;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        frame_last;
    } t_out_word;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pix;

    // column word: bright rows r-1..r-4 and original rows r-1, r-2
    typedef struct packed {
        t_pix b1;
        t_pix b2;
        t_pix b3;
        t_pix b4;
        t_pix o1;
        t_pix o2;
    } t_line_word;

endpackage

// ----- src/btba_ram.sv -----
// ----------------------------------------------------------------------------
// btba_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module btba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

// ----- src/bloom_threshold_blur_add_unit.sv -----
// ----------------------------------------------------------------------------
// bloom_threshold_blur_add_unit
// Bloom on a raster pixel stream: threshold, 5x5 binomial blur, add, saturate.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output queue has room; the column
// line RAM is read and written back once per word, with forwarding when
// consecutive words hit the same column. Results pass stages 1 and 2 into the
// output queue and lag the input stream by 2 lines plus 2 words.
// Reset: synchronous, active low; clears position, counters, pipeline and the
// output queue. The line RAM is not cleared and needs no clearing pass.
module bloom_threshold_blur_add_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  btba_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output btba_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  btba_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = $bits(btba_pkg::t_line_word);

    function automatic logic [15:0] tap5(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d,
                                         input logic [15:0] e);
        logic [19:0] s;
        s = 20'(a) + 20'(e) + ((20'(b) + 20'(d)) << 2) + (20'(c) << 2) + (20'(c) << 1);
        return s[19:4];
    endfunction

    // configuration
    logic        r_enable;
    logic [15:0] r_thresh;
    logic [11:0] r_width;
    logic [11:0] r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_thresh <= 16'd3277;
            r_width  <= 12'd640;
            r_height <= 12'd480;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                btba_pkg::CFG_BLOOM_ENABLE:     r_enable <= i_cfg_data[0];
                btba_pkg::CFG_BRIGHT_THRESHOLD: r_thresh <= i_cfg_data;
                btba_pkg::CFG_FRAME_WIDTH:      r_width  <= i_cfg_data[11:0];
                btba_pkg::CFG_FRAME_HEIGHT:     r_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic [11:0] wc, hc;
    always_comb begin
        if (r_width == 12'd0) wc = 12'd1;
        else if (14'(r_width) > 14'(MAX_WIDTH)) wc = 12'(MAX_WIDTH);
        else wc = r_width;
        if (r_height == 12'd0) hc = 12'd1;
        else if (14'(r_height) > 14'(MAX_HEIGHT)) hc = 12'(MAX_HEIGHT);
        else hc = r_height;
    end

    // stage 0: position bookkeeping
    logic [11:0] r_row, r_col, r_orow, r_ocol;
    logic [13:0] r_fill;
    logic [11:0] n_row, n_col, n_orow, n_ocol;
    logic [13:0] n_fill;
    logic        in_acc, in_frame, bright, s0_emit, s0_last;
    logic [13:0] delay;
    btba_pkg::t_pix px, br;
    logic [2:0]  s0_j [5];
    logic [2:0]  s0_d [5];
    logic signed [13:0] qs [5];
    logic signed [13:0] xs [5];
    logic [11:0] q [5];
    logic [11:0] x [5];

    logic r_s1_valid, r_s2_valid;
    logic [2:0] r_cnt;

    assign o_in_ready = (r_cnt + 3'(r_s1_valid) + 3'(r_s2_valid)) < 3'd4;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        in_frame = r_row < hc;
        px = '0;
        if (in_frame && !i_in_word.is_pad) begin
            px = '{red: i_in_word.red_in, green: i_in_word.green_in,
                   blue: i_in_word.blue_in};
        end
        bright = (px.red > r_thresh) && (px.green > r_thresh) && (px.blue > r_thresh);
        br = bright ? px : '0;
        delay = {1'b0, wc, 1'b0} + 14'd2;
        s0_emit = r_fill >= delay;
        s0_last = (r_orow == hc - 12'd1) && (r_ocol == wc - 12'd1);
        for (int k = 0; k < 5; k++) begin
            qs[k] = $signed(14'(r_row) + 14'(k) - 14'd4);
            if (qs[k] < 0) q[k] = 12'd0;
            else if (qs[k] >= $signed(14'(hc))) q[k] = hc - 12'd1;
            else q[k] = qs[k][11:0];
            s0_j[k] = 3'(r_row - q[k]);
            xs[k] = $signed(14'(r_ocol) + 14'(k) - 14'd2);
            if (xs[k] < 0) x[k] = 12'd0;
            else if (xs[k] >= $signed(14'(wc))) x[k] = wc - 12'd1;
            else x[k] = xs[k][11:0];
            s0_d[k] = 3'(r_ocol + 12'd2 - x[k]);
        end
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_fill = r_fill;
        n_orow = r_orow;
        n_ocol = r_ocol;
        if (s0_emit && s0_last) begin
            n_row  = '0;
            n_col  = '0;
            n_fill = '0;
            n_orow = '0;
            n_ocol = '0;
        end else begin
            if (!s0_emit) n_fill = r_fill + 14'd1;
            if (r_col + 12'd1 >= wc) begin
                n_col = '0;
                n_row = r_row + 12'd1;
            end else begin
                n_col = r_col + 12'd1;
            end
            if (s0_emit) begin
                if (r_ocol + 12'd1 >= wc) begin
                    n_ocol = '0;
                    n_orow = r_orow + 12'd1;
                end else begin
                    n_ocol = r_ocol + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_fill <= '0;
            r_orow <= '0;
            r_ocol <= '0;
        end else if (in_acc) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_fill <= n_fill;
            r_orow <= n_orow;
            r_ocol <= n_ocol;
        end
    end

    // stage 1: line RAM read-modify-write, column pass
    logic [AW-1:0]  r_s1_addr;
    btba_pkg::t_pix r_s1_br, r_s1_px;
    logic [2:0]     r_s1_j [5];
    logic [2:0]     r_s1_d [5];
    logic           r_s1_emit, r_s1_last;
    logic           r_fwd_hit;
    logic [LW-1:0]  r_fwd_word;
    logic [LW-1:0]  ram_rdata;
    btba_pkg::t_line_word lw, wb;
    btba_pkg::t_pix bsel [5];
    btba_pkg::t_pix vcol;
    btba_pkg::t_pix r_od1, r_od2;

    btba_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (wb),
        .i_raddr (AW'(r_col)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        lw = r_fwd_hit ? btba_pkg::t_line_word'(r_fwd_word)
                       : btba_pkg::t_line_word'(ram_rdata);
        wb = '{b1: r_s1_br, b2: lw.b1, b3: lw.b2, b4: lw.b3, o1: r_s1_px, o2: lw.o1};
        for (int k = 0; k < 5; k++) begin
            case (r_s1_j[k])
                3'd0:    bsel[k] = r_s1_br;
                3'd1:    bsel[k] = lw.b1;
                3'd2:    bsel[k] = lw.b2;
                3'd3:    bsel[k] = lw.b3;
                default: bsel[k] = lw.b4;
            endcase
        end
        vcol.red   = tap5(bsel[0].red, bsel[1].red, bsel[2].red, bsel[3].red, bsel[4].red);
        vcol.green = tap5(bsel[0].green, bsel[1].green, bsel[2].green, bsel[3].green,
                          bsel[4].green);
        vcol.blue  = tap5(bsel[0].blue, bsel[1].blue, bsel[2].blue, bsel[3].blue,
                          bsel[4].blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            r_fwd_hit  <= in_acc && r_s1_valid && (AW'(r_col) == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_word <= wb;
        if (in_acc) begin
            r_s1_addr <= AW'(r_col);
            r_s1_br   <= br;
            r_s1_px   <= px;
            r_s1_j    <= s0_j;
            r_s1_d    <= s0_d;
            r_s1_emit <= s0_emit;
            r_s1_last <= s0_last;
        end
        if (r_s1_valid) begin
            r_od1 <= lw.o2;
            r_od2 <= r_od1;
        end
    end

    // stage 2: row pass over the tap window, add and saturate (original passed through when bloom is disabled)
    btba_pkg::t_pix r_v, r_s2_orig;
    btba_pkg::t_pix r_win [4];
    logic [2:0]     r_s2_d [5];
    logic           r_s2_emit, r_s2_last;
    btba_pkg::t_pix tsel [5];
    btba_pkg::t_pix hsum;
    logic [16:0]    sum_r, sum_g, sum_b;
    btba_pkg::t_out_word res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_v       <= vcol;
            r_s2_orig <= r_od2;
            r_s2_d    <= r_s1_d;
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
        end
        if (r_s2_valid) begin
            r_win[0] <= r_v;
            r_win[1] <= r_win[0];
            r_win[2] <= r_win[1];
            r_win[3] <= r_win[2];
        end
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            case (r_s2_d[k])
                3'd0:    tsel[k] = r_v;
                3'd1:    tsel[k] = r_win[0];
                3'd2:    tsel[k] = r_win[1];
                3'd3:    tsel[k] = r_win[2];
                default: tsel[k] = r_win[3];
            endcase
        end
        hsum.red   = tap5(tsel[0].red, tsel[1].red, tsel[2].red, tsel[3].red, tsel[4].red);
        hsum.green = tap5(tsel[0].green, tsel[1].green, tsel[2].green, tsel[3].green,
                          tsel[4].green);
        hsum.blue  = tap5(tsel[0].blue, tsel[1].blue, tsel[2].blue, tsel[3].blue,
                          tsel[4].blue);
        sum_r = 17'(r_s2_orig.red) + 17'(hsum.red);
        sum_g = 17'(r_s2_orig.green) + 17'(hsum.green);
        sum_b = 17'(r_s2_orig.blue) + 17'(hsum.blue);
        res.frame_last = r_s2_last;
        if (r_enable) begin
            res.red_out   = (sum_r > 17'(btba_pkg::ONE_FIXED)) ? btba_pkg::ONE_FIXED
                                                               : sum_r[15:0];
            res.green_out = (sum_g > 17'(btba_pkg::ONE_FIXED)) ? btba_pkg::ONE_FIXED
                                                               : sum_g[15:0];
            res.blue_out  = (sum_b > 17'(btba_pkg::ONE_FIXED)) ? btba_pkg::ONE_FIXED
                                                               : sum_b[15:0];
        end else begin
            res.red_out   = r_s2_orig.red;
            res.green_out = r_s2_orig.green;
            res.blue_out  = r_s2_orig.blue;
        end
    end

    // output queue
    btba_pkg::t_out_word r_fq [4];
    logic [1:0] r_wp, r_rp;
    logic       push, pop;

    assign push        = r_s2_valid && r_s2_emit;
    assign o_out_valid = r_cnt != 3'd0;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_word  = r_fq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fq[r_wp] <= res;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < 3'd4 || pop))
        else $error("output queue overflow");

    a_fwd_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forward without a word in stage 1");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s0_emit && s0_last) |=> (r_row == '0 && r_col == '0 && r_fill == '0))
        else $error("position not restarted after frame end");

endmodule

// ----- bench/tb_bloom_threshold_blur_add_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_threshold_blur_add_unit
// Self-checking bench: whole frames of random and corner-case pixels are
// streamed under several register settings and random handshake idling, and
// every result word is compared against a bit-accurate bloom predictor.
// ----------------------------------------------------------------------------
module tb_bloom_threshold_blur_add_unit;

    localparam int MAXW       = 2048;
    localparam int MAXH       = 2048;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYC   = 300;

    class bloom_scoreboard;
        logic [15:0]  bright_mem [4*MAXW][3];
        logic [15:0]  orig_mem   [4*MAXW][3];
        logic [15:0]  vsum_mem   [4*MAXW][3];
        int unsigned  col_pos, row_pos;
        logic         en_r;
        logic [15:0]  thr_r;
        logic [11:0]  wid_r, hgt_r;
        btba_pkg::t_out_word pending_q[$];
        int unsigned  n_results;

        function new();
            en_r = 1'b1; thr_r = 16'd3277; wid_r = 12'd640; hgt_r = 12'd480;
            col_pos = 0; row_pos = 0; n_results = 0;
        endfunction

        function void set_reg(btba_pkg::t_cfg_index idx, logic [15:0] val);
            case (idx)
                btba_pkg::CFG_BLOOM_ENABLE:     en_r  = val[0];
                btba_pkg::CFG_BRIGHT_THRESHOLD: thr_r = val;
                btba_pkg::CFG_FRAME_WIDTH:      wid_r = val[11:0];
                btba_pkg::CFG_FRAME_HEIGHT:     hgt_r = val[11:0];
                default: ;
            endcase
        endfunction

        function int unsigned fit(int v, int unsigned lim);
            if (v < 0) return 0;
            if (v >= int'(lim)) return lim - 1;
            return v;
        endfunction

        function int unsigned slot(int unsigned r, int unsigned c);
            return (r & 3) * MAXW + (c % MAXW);
        endfunction

        function void note_input(btba_pkg::t_in_word d);
            int unsigned w, h, r, c, n, dly, m, cr, cc, vr, q, x, v, orig, sl;
            int unsigned px[3], br[3], acc[3], wt[5];
            bit          in_frame, bright, last;
            btba_pkg::t_out_word o;
            wt = '{1, 4, 6, 4, 1};
            w = (wid_r == 0) ? 1 : ((wid_r > MAXW) ? MAXW : wid_r);
            h = (hgt_r == 0) ? 1 : ((hgt_r > MAXH) ? MAXH : hgt_r);
            r = row_pos;
            c = col_pos;
            in_frame = r < h;
            px = '{0, 0, 0};
            if (c >= MAXW) c = 0;
            if (in_frame && !d.is_pad) px = '{d.red_in, d.green_in, d.blue_in};
            bright = px[0] > thr_r && px[1] > thr_r && px[2] > thr_r;
            for (int ch = 0; ch < 3; ch++) br[ch] = bright ? px[ch] : 0;
            if (r >= 2 && r - 2 < h) begin
                vr = r - 2;
                acc = '{0, 0, 0};
                for (int k = 0; k < 5; k++) begin
                    q = fit(int'(vr) + k - 2, h);
                    for (int ch = 0; ch < 3; ch++)
                        acc[ch] += wt[k] * ((q == r) ? br[ch] : bright_mem[slot(q, c)][ch]);
                end
                for (int ch = 0; ch < 3; ch++) vsum_mem[slot(vr, c)][ch] = 16'(acc[ch] >> 4);
            end
            n = r * w + c;
            dly = 2 * w + 2;
            if (n >= dly) begin
                m = n - dly;
                cr = m / w;
                cc = m % w;
                last = m >= w * h - 1;
                acc = '{0, 0, 0};
                for (int k = 0; k < 5; k++) begin
                    x = fit(int'(cc) + k - 2, w);
                    for (int ch = 0; ch < 3; ch++) acc[ch] += wt[k] * vsum_mem[slot(cr, x)][ch];
                end
                for (int ch = 0; ch < 3; ch++) begin
                    orig = orig_mem[slot(cr, cc)][ch];
                    v = orig;
                    if (en_r) begin
                        v = orig + (acc[ch] >> 4);
                        if (v > btba_pkg::ONE_FIXED) v = btba_pkg::ONE_FIXED;
                    end
                    acc[ch] = v;
                end
                o.red_out = acc[0][15:0];
                o.green_out = acc[1][15:0];
                o.blue_out = acc[2][15:0];
                o.frame_last = last;
                pending_q = {pending_q, o};
                if (last) begin
                    if (in_frame) begin
                        sl = slot(row_pos, col_pos % MAXW);
                        for (int ch = 0; ch < 3; ch++) begin
                            bright_mem[sl][ch] = 16'(br[ch]);
                            orig_mem[sl][ch] = 16'(px[ch]);
                        end
                    end
                    row_pos = 0;
                    col_pos = 0;
                    return;
                end
            end
            if (in_frame) begin
                for (int ch = 0; ch < 3; ch++) begin
                    bright_mem[slot(r, c)][ch] = 16'(br[ch]);
                    orig_mem[slot(r, c)][ch] = 16'(px[ch]);
                end
            end
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1) & 12'hFFF;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function bit check(btba_pkg::t_out_word got, output string msg);
            btba_pkg::t_out_word e;
            if (pending_q.size() == 0) begin
                msg = $sformatf("unexpected result %h", got);
                return 0;
            end
            e = pending_q.pop_front();
            n_results++;
            msg = "";
            if (got.red_out !== e.red_out)
                msg = {msg, $sformatf(" red %h/%h", got.red_out, e.red_out)};
            if (got.green_out !== e.green_out)
                msg = {msg, $sformatf(" green %h/%h", got.green_out, e.green_out)};
            if (got.blue_out !== e.blue_out)
                msg = {msg, $sformatf(" blue %h/%h", got.blue_out, e.blue_out)};
            if (got.frame_last !== e.frame_last)
                msg = {msg, $sformatf(" last %b/%b", got.frame_last, e.frame_last)};
            return msg == "";
        endfunction
    endclass

    logic       i_clk, i_rst_n;
    logic       i_in_valid, o_in_ready;
    btba_pkg::t_in_word   i_in_word;
    logic       o_out_valid, i_out_ready;
    btba_pkg::t_out_word  o_out_word;
    logic       i_cfg_valid, o_cfg_ready;
    btba_pkg::t_cfg_index i_cfg_index;
    logic [15:0] i_cfg_data;

    bloom_scoreboard sb;
    int unsigned n_errors, n_items, n_frames, idle_cnt;
    int unsigned send_idle, recv_idle, hold_token, hold_seen, hold_left;

    bloom_threshold_blur_add_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report(string msg);
        n_errors++;
        $display("MISMATCH @%0t:%s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_word);
            if (o_out_valid && i_out_ready) begin
                if (!sb.check(o_out_word, msg)) report(msg);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                    (o_out_valid && i_out_ready)) begin
                idle_cnt <= 0;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random idling plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic wait_accept(ref logic rdy);
        bit hit;
        do begin
            @(negedge i_clk);
            hit = rdy;
            @(posedge i_clk);
        end while (!hit);
    endtask

    task automatic write_reg(btba_pkg::t_cfg_index idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        wait_accept(o_cfg_ready);
    endtask

    task automatic send_word(btba_pkg::t_in_word d);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= d;
        wait_accept(o_in_ready);
        n_items++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_thr(logic [15:0] thr);
        int unsigned v;
        v = thr + $urandom_range(3);
        return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic run_frame(bit en, logic [15:0] thr, logic [15:0] w_raw, logic [15:0] h_raw);
        int unsigned w, h, total;
        btba_pkg::t_in_word d;
        write_reg(btba_pkg::CFG_BLOOM_ENABLE, {15'($urandom), en});
        write_reg(btba_pkg::CFG_BRIGHT_THRESHOLD, thr);
        write_reg(btba_pkg::CFG_FRAME_WIDTH, w_raw);
        write_reg(btba_pkg::CFG_FRAME_HEIGHT, h_raw);
        i_cfg_valid <= 1'b0;
        w = (w_raw[11:0] == 0) ? 1 : ((w_raw[11:0] > MAXW) ? MAXW : w_raw[11:0]);
        h = (h_raw[11:0] == 0) ? 1 : ((h_raw[11:0] > MAXH) ? MAXH : h_raw[11:0]);
        total = w * h + 2 * w + 2;
        for (int unsigned i = 0; i < total; i++) begin
            d = btba_pkg::t_in_word'(49'({$urandom, $urandom}));
            if ($urandom_range(1)) begin
                d.red_in = near_thr(thr);
                d.green_in = near_thr(thr);
                d.blue_in = near_thr(thr);
            end else if ($urandom_range(2) == 0) begin
                d.red_in = 16'($urandom_range(4600, 3000));
                d.green_in = 16'($urandom_range(4600, 3000));
                d.blue_in = 16'($urandom_range(4600, 3000));
            end
            if (i < w * h) d.is_pad = ($urandom_range(19) == 0);
            send_word(d);
        end
        drain();
        n_frames++;
    endtask

    initial begin
        int unsigned mark;
        sb = new();
        i_clk = 1'b0; i_rst_n = 1'b0;
        i_in_valid = 1'b0; i_in_word = '0; i_out_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = btba_pkg::CFG_BLOOM_ENABLE; i_cfg_data = '0;
        n_errors = 0; n_items = 0; n_frames = 0; idle_cnt = 0;
        send_idle = 28; recv_idle = 58; hold_token = 0; hold_seen = 0; hold_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_frame(1'b1, 16'h0000, 16'd1, 16'd1);
        run_frame(1'b1, 16'hFFFF, 16'd2, 16'd2);
        run_frame(1'b0, 16'h0000, 16'd3, 16'd2);
        run_frame(1'b1, 16'd3277, 16'hF000, 16'd3);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 28 : ((mode == 1) ? 58 : 0);
            recv_idle = (mode == 0) ? 58 : ((mode == 1) ? 28 : 0);
            mark = n_items;
            if (mode == 2) begin
                hold_token++;
                run_frame(1'b1, 16'd2048, 16'd8, 16'd8);
                run_frame(1'b1, 16'd3277, 16'hF003, 16'h1002);
                run_frame(1'b1, 16'h0000, 16'd5, 16'h0000);
                mark = n_items;
            end
            while (n_items - mark < 190)
                run_frame($urandom_range(3) != 0,
                          ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 2048)),
                          16'($urandom_range(8, 1)), 16'($urandom_range(6, 1)));
        end
        drain();
        $display("covered %0d frames, %0d input words, %0d results checked",
                 n_frames, n_items, sb.n_results);
        $display("small frames with zero and wide size registers, bloom on and off, stalls and fill-up");
        if (n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
